@@ rtl/b64e_pkg.sv @@
package b64e_pkg;

    localparam logic [6:0] PAD_CHAR = 7'h3D;

    typedef enum logic [1:0] {
        FILL0 = 2'd0,
        FILL2 = 2'd1,
        FILL4 = 2'd2
    } t_fill;

    typedef struct packed {
        logic [3:0][6:0] chars;
        logic [1:0]      last_idx;
        logic            eom;
    } t_job;

    function automatic logic [6:0] sextet_char(input logic [5:0] idx);
        logic [6:0] wide;
        wide = {1'b0, idx};
        case (idx) inside
            [6'd0:6'd25]:  sextet_char = wide + 7'h41;
            [6'd26:6'd51]: sextet_char = wide + 7'h47;
            [6'd52:6'd61]: sextet_char = wide - 7'h04;
            6'd62:         sextet_char = 7'h2B;
            default:       sextet_char = 7'h2F;
        endcase
    endfunction

endpackage

@@ rtl/base64_stream_encoder_top.sv @@
// a byte's first character passes through the queue and then the output register before it is shown
// throughput: one character per cycle while i_stall is low, set by the single output register
// a byte yields one or two characters, four at most on the final byte
// so a byte yields about 1.33 characters on average over a long message
// reset: synchronous active low, empties the queue and clears pending bits and output valid
module base64_stream_encoder_top #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_data_byte,
    input  logic       i_end_of_message,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [6:0] o_out_char,
    output logic       o_last_char
);
    import b64e_pkg::*;

    t_job front_job;
    t_job head_job;
    logic push;
    logic pop;
    logic q_full;
    logic q_empty;

    b64e_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .i_data_byte     (i_data_byte),
        .i_end_of_message(i_end_of_message),
        .i_full          (q_full),
        .o_stall         (o_stall),
        .o_push          (push),
        .o_job           (front_job)
    );

    b64e_queue #(
        .WIDTH($bits(t_job)),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_wdata(front_job),
        .i_pop  (pop),
        .o_rdata(head_job),
        .o_full (q_full),
        .o_empty(q_empty)
    );

    b64e_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_empty  (q_empty),
        .i_job      (head_job),
        .o_pop      (pop),
        .i_stall    (i_stall),
        .o_valid    (o_valid),
        .o_out_char (o_out_char),
        .o_last_char(o_last_char)
    );

endmodule

@@ rtl/b64e_queue.sv @@
module b64e_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_full,
    output logic             o_empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wptr;
    logic [PW-1:0]    r_rptr;
    logic [CW-1:0]    r_cnt;
    logic             wr;
    logic             rd;

    assign o_full  = (r_cnt == FULL_CNT);
    assign o_empty = (r_cnt == '0);
    assign o_rdata = r_mem[r_rptr];
    assign wr      = i_push && !o_full;
    assign rd      = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (wr) begin
                r_wptr <= (r_wptr == LAST_PTR) ? '0 : r_wptr + 1'b1;
            end
            if (rd) begin
                r_rptr <= (r_rptr == LAST_PTR) ? '0 : r_rptr + 1'b1;
            end
            if (wr && !rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (rd && !wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

endmodule

@@ rtl/b64e_front.sv @@
module b64e_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [7:0]    i_data_byte,
    input  logic          i_end_of_message,
    input  logic          i_full,
    output logic          o_stall,
    output logic          o_push,
    output b64e_pkg::t_job o_job
);
    import b64e_pkg::*;

    t_fill      r_fill;
    t_fill      n_fill;
    logic [3:0] r_pend;
    logic [3:0] n_pend;

    assign o_stall = i_full;
    assign o_push  = i_valid && !i_full;

    always_comb begin
        o_job.chars    = {4{PAD_CHAR}};
        o_job.last_idx = 2'd0;
        o_job.eom      = i_end_of_message;
        n_fill         = FILL0;
        n_pend         = 4'd0;
        case (r_fill)
            FILL0: begin
                o_job.chars[0] = sextet_char(i_data_byte[7:2]);
                n_fill         = FILL2;
                n_pend         = {2'b00, i_data_byte[1:0]};
                if (i_end_of_message) begin
                    o_job.chars[1] = sextet_char({i_data_byte[1:0], 4'b0000});
                    o_job.last_idx = 2'd3;
                end
            end
            FILL2: begin
                o_job.chars[0] = sextet_char({r_pend[1:0], i_data_byte[7:4]});
                n_fill         = FILL4;
                n_pend         = i_data_byte[3:0];
                if (i_end_of_message) begin
                    o_job.chars[1] = sextet_char({i_data_byte[3:0], 2'b00});
                    o_job.last_idx = 2'd2;
                end
            end
            FILL4: begin
                o_job.chars[0] = sextet_char({r_pend, i_data_byte[7:6]});
                o_job.chars[1] = sextet_char(i_data_byte[5:0]);
                o_job.last_idx = 2'd1;
            end
            default: begin
                n_fill = FILL0;
            end
        endcase
        if (i_end_of_message) begin
            n_fill = FILL0;
            n_pend = 4'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= FILL0;
            r_pend <= 4'd0;
        end else if (o_push) begin
            r_fill <= n_fill;
            r_pend <= n_pend;
        end
    end

endmodule

@@ rtl/b64e_back.sv @@
module b64e_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_empty,
    input  b64e_pkg::t_job i_job,
    output logic           o_pop,
    input  logic           i_stall,
    output logic           o_valid,
    output logic [6:0]     o_out_char,
    output logic           o_last_char
);
    import b64e_pkg::*;

    logic       r_valid;
    logic [1:0] r_idx;
    logic [6:0] r_char;
    logic       r_last;
    logic       out_ready;
    logic       take;
    logic       job_done;

    assign out_ready   = !r_valid || !i_stall;
    assign take        = !i_q_empty && out_ready;
    assign job_done    = (r_idx == i_job.last_idx);
    assign o_pop       = take && job_done;
    assign o_valid     = r_valid;
    assign o_out_char  = r_char;
    assign o_last_char = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else if (out_ready) begin
            r_valid <= !i_q_empty;
            if (take) begin
                r_idx <= job_done ? 2'd0 : r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_char <= i_job.chars[r_idx];
            r_last <= i_job.eom && job_done;
        end
    end

endmodule

@@ rtl/b64e_checker.sv @@
module b64e_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_stall,
    input logic [7:0] i_data_byte,
    input logic       i_end_of_message,
    input logic       o_valid,
    input logic       i_stall,
    input logic [6:0] o_out_char,
    input logic       o_last_char
);

    // stalled word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out_char) && $stable(o_last_char))
        else $error("output word changed under stall");

    // reset empties the output register
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // reset empties the queue
    a_rst_in: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_stall)
        else $error("input stalled after reset");

endmodule

bind base64_stream_encoder_top b64e_checker u_b64e_checker (.*);
